/* rtl/rita_pkg.sv */
// ----------------------------------------------------------------------------
// rita_pkg
// Shared constants, codes and helpers for the radix integer to ASCII converter.
// ----------------------------------------------------------------------------
package rita_pkg;

    localparam int DEF_WORD_WIDTH = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    // unused radix code falls back to hex
    function automatic logic [4:0] base_of(input logic [1:0] code);
        logic [4:0] b;
        unique case (code)
            RADIX_OCT: b = BASE_OCT;
            RADIX_DEC: b = BASE_DEC;
            default:   b = BASE_HEX;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CHAR_UPPER + {4'd0, d} - 8'd10;
        end else begin
            c = CHAR_LOWER + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* rtl/radix_integer_to_ascii.sv */
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts one integer to its octal, decimal or hex ASCII text, one character
// per output transaction, most significant character first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries the value and its format flags.
//   o_stall stays high from the accepted transaction until its last character
//   has been loaded into the output register, so one number is in work at a
//   time. Output channel o_valid / i_stall carries o_character and
//   o_last_char, which marks the final character of the number.
//   Sequence: an optional two's complement pass for negative signed
//   decimal values, then a bit-serial restoring divider for each digit
//   (one remainder bit per cycle), then the characters are loaded into
//   the output register in turn while the receiver does not stall.
//   Digits are kept on a small stack and read back in reverse order.
//   A stalled output register holds its character; the next character is
//   loaded only once the held one is taken.
//   Reset (synchronous, active low) returns to idle with no output pending.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
    parameter int WORD_WIDTH = rita_pkg::DEF_WORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_radix,
    input  logic        i_upper_case,
    input  logic        i_wide_mode,
    input  logic        i_signed_mode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last_char
);
    import rita_pkg::*;

    localparam int DEPTH = (WORD_WIDTH + 2) / 3;
    localparam int SP_W  = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WORD_WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_LOW = CNT_W'(WORD_WIDTH - 32);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NEG  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [3:0]            r_rem, n_rem;
    logic [4:0]            r_base, n_base;
    logic                  r_upper, n_upper;
    logic                  r_wide, n_wide;
    logic                  r_neg, n_neg;
    logic                  r_carry, n_carry;
    logic                  r_qnz, n_qnz;
    logic [SP_W-1:0]       r_sp, n_sp;
    logic                  r_valid, n_valid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;
    logic [3:0]            r_stk [DEPTH];

    logic                  in_acc;
    logic                  out_free;
    logic [4:0]            div_t;
    logic                  div_ge;
    logic [4:0]            div_r;
    logic                  neg_bit;
    logic                  push;
    logic [SP_W-1:0]       sp_dec;
    logic                  sign_bit;
    logic [WORD_WIDTH-1:0] load_val;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_valid || !i_stall;

    assign div_t  = {r_rem, r_val[WORD_WIDTH-1]};
    assign div_ge = (div_t >= r_base);
    assign div_r  = div_ge ? (div_t - r_base) : div_t;
    assign sp_dec = r_sp - SP_W'(1);

    assign sign_bit = i_wide_mode ? i_value[WORD_WIDTH-1] : i_value[31];
    assign load_val = i_wide_mode ? i_value[WORD_WIDTH-1:0]
                                  : WORD_WIDTH'(i_value[31:0]);

    // bits above bit 31 are forced to zero in 32-bit mode
    assign neg_bit = (r_wide || (r_cnt >= CNT_LOW)) ? (~r_val[0] ^ r_carry) : 1'b0;

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_base  = r_base;
        n_upper = r_upper;
        n_wide  = r_wide;
        n_neg   = r_neg;
        n_carry = r_carry;
        n_qnz   = r_qnz;
        n_sp    = r_sp;
        n_valid = r_valid && i_stall;
        n_char  = r_char;
        n_last  = r_last;
        push    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val   = load_val;
                    n_base  = base_of(i_radix);
                    n_upper = i_upper_case;
                    n_wide  = i_wide_mode;
                    n_neg   = (i_radix == RADIX_DEC) && i_signed_mode && sign_bit;
                    n_cnt   = CNT_TOP;
                    n_carry = 1'b1;
                    n_rem   = 4'd0;
                    n_qnz   = 1'b0;
                    n_sp    = '0;
                    n_state = n_neg ? S_NEG : S_DIV;
                end
            end
            S_NEG: begin
                n_val   = {neg_bit, r_val[WORD_WIDTH-1:1]};
                n_carry = ~r_val[0] & r_carry;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_TOP;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_val = {r_val[WORD_WIDTH-2:0], div_ge};
                n_rem = div_r[3:0];
                n_qnz = r_qnz | div_ge;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    push  = 1'b1;
                    n_sp  = r_sp + SP_W'(1);
                    n_cnt = CNT_TOP;
                    n_rem = 4'd0;
                    n_qnz = 1'b0;
                    if (!(r_qnz | div_ge)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    if (r_neg) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = digit_char(r_stk[sp_dec[IDX_W-1:0]], r_upper);
                        n_last = (r_sp == SP_W'(1));
                        n_sp   = sp_dec;
                        if (r_sp == SP_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_sp    <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_sp    <= n_sp;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
        end
        r_val   <= n_val;
        r_rem   <= n_rem;
        r_base  <= n_base;
        r_upper <= n_upper;
        r_wide  <= n_wide;
        r_carry <= n_carry;
        r_qnz   <= n_qnz;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    // digit stack
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stk[r_sp[IDX_W-1:0]] <= div_r[3:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(DEPTH))
        else $error("digit stack overflow");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> {1'b0, r_rem} < r_base)
        else $error("remainder not below radix");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_sp != '0)
        else $error("emit with empty digit stack");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && !r_neg && r_sp == SP_W'(1))
            |=> (r_state == S_IDLE && o_valid && o_last_char))
        else $error("last character not followed by idle");

endmodule

/* tb/radix_integer_to_ascii_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_checker
// Watches both channels of the integer to ASCII converter. Every accepted
// number is turned into its expected character string, and every accepted
// output character is compared in order against that string.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_radix,
    input  logic        i_upper_case,
    input  logic        i_wide_mode,
    input  logic        i_signed_mode,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    output int          o_errors,
    output int          o_chars_pending,
    output int          o_chars_checked
);
    import rita_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char text_q[$];

    int errors_q  = 0;
    int pending_q = 0;
    int checked_q = 0;

    assign o_errors        = errors_q;
    assign o_chars_pending = pending_q;
    assign o_chars_checked = checked_q;

    function automatic void queue_text(input logic [63:0] value, input logic [1:0] radix,
                                       input logic upper, input logic wide, input logic sgn);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] rem;
        logic        neg;
        logic [7:0]  digs [22];
        int          nd;
        t_text_char  tc;
        mask = wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
        mag  = value & mask;
        unique case (radix)
            RADIX_OCT: base = 64'd8;
            RADIX_DEC: base = 64'd10;
            default:   base = 64'd16;
        endcase
        neg = (radix == RADIX_DEC) && sgn && (wide ? mag[63] : mag[31]);
        if (neg) begin
            mag = (~mag + 64'd1) & mask;
        end
        nd = 0;
        do begin
            rem = mag % base;
            mag = mag / base;
            if (rem < 64'd10) begin
                digs[nd] = CHAR_ZERO + rem[7:0];
            end else begin
                digs[nd] = (upper ? CHAR_UPPER : CHAR_LOWER) + rem[7:0] - 8'd10;
            end
            nd++;
        end while (mag != 64'd0 && nd < 22);
        if (neg) begin
            tc.ch   = CHAR_MINUS;
            tc.last = 1'b0;
            text_q.push_back(tc);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            tc.ch   = digs[k];
            tc.last = (k == 0);
            text_q.push_back(tc);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        int         bad;
        bad = 0;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected character, expected none, actual %h last %b",
                             $time, i_character, i_last_char);
                    bad++;
                end else begin
                    want = text_q.pop_front();
                    if (want.ch !== i_character) begin
                        $display("%0t: character mismatch, expected %h, actual %h",
                                 $time, want.ch, i_character);
                        bad++;
                    end
                    if (want.last !== i_last_char) begin
                        $display("%0t: last_char mismatch, expected %b, actual %b",
                                 $time, want.last, i_last_char);
                        bad++;
                    end
                    checked_q <= checked_q + 1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                queue_text(i_value, i_radix, i_upper_case, i_wide_mode, i_signed_mode);
            end
            errors_q  <= errors_q + bad;
            pending_q <= text_q.size();
        end
    end

endmodule

/* tb/tb_radix_integer_to_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_integer_to_ascii
// Drives numbers into the integer to ASCII converter: a directed set of
// extremes and corner formats, then random values over all radix codes,
// widths and flags, with random idle cycles on the sender and stalls on the
// receiver. The checker beside the block predicts and compares the text.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_ascii;
    import rita_pkg::*;

    localparam logic [1:0] RADIX_SPARE = 2'd3;
    localparam int         NUM_RANDOM  = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [63:0] i_value       = '0;
    logic [1:0]  i_radix       = RADIX_OCT;
    logic        i_upper_case  = 1'b0;
    logic        i_wide_mode   = 1'b0;
    logic        i_signed_mode = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last_char;

    int errors;
    int chars_pending;
    int chars_checked;
    int numbers_sent = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;

    always #6 i_clk = ~i_clk;

    radix_integer_to_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_upper_case  (i_upper_case),
        .i_wide_mode   (i_wide_mode),
        .i_signed_mode (i_signed_mode),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last_char   (o_last_char)
    );

    radix_integer_to_ascii_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_value         (i_value),
        .i_radix         (i_radix),
        .i_upper_case    (i_upper_case),
        .i_wide_mode     (i_wide_mode),
        .i_signed_mode   (i_signed_mode),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_character     (o_character),
        .i_last_char     (o_last_char),
        .o_errors        (errors),
        .o_chars_pending (chars_pending),
        .o_chars_checked (chars_checked)
    );

    always @(posedge i_clk) begin
        i_stall <= rx_idle_on && ($urandom_range(99) < 32);
    end

    task automatic send_number(input logic [63:0] v, input logic [1:0] r, input logic up,
                               input logic w, input logic s);
        while (tx_idle_on && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= v;
        i_radix       <= r;
        i_upper_case  <= up;
        i_wide_mode   <= w;
        i_signed_mode <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        numbers_sent++;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = v >> $urandom_range(0, 63);
            1: v = 64'($urandom_range(0, 20));
            2: v = v | 64'h8000_0000_8000_0000;
            3: v = ~(v >> $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_number(64'd0, RADIX_OCT, 1'b0, 1'b0, 1'b0);
        send_number(64'd0, RADIX_DEC, 1'b0, 1'b1, 1'b1);
        send_number(64'd0, RADIX_HEX, 1'b1, 1'b1, 1'b0);
        send_number({64{1'b1}}, RADIX_HEX, 1'b0, 1'b1, 1'b0);
        send_number({64{1'b1}}, RADIX_HEX, 1'b1, 1'b1, 1'b0);
        send_number(64'hDEAD_BEEF_CAFE_F00D, RADIX_HEX, 1'b1, 1'b0, 1'b0);
        send_number(64'hDEAD_BEEF_CAFE_F00D, RADIX_HEX, 1'b0, 1'b0, 1'b1);
        send_number({64{1'b1}}, RADIX_OCT, 1'b1, 1'b1, 1'b0);
        send_number({64{1'b1}}, RADIX_OCT, 1'b0, 1'b0, 1'b1);
        send_number({64{1'b1}}, RADIX_DEC, 1'b1, 1'b1, 1'b0);
        send_number(64'h8000_0000_0000_0000, RADIX_DEC, 1'b0, 1'b1, 1'b1);
        send_number(64'hFFFF_FFFF_8000_0000, RADIX_DEC, 1'b0, 1'b0, 1'b1);
        send_number({64{1'b1}}, RADIX_DEC, 1'b0, 1'b1, 1'b1);
        send_number({64{1'b1}}, RADIX_DEC, 1'b0, 1'b0, 1'b1);
        send_number(64'h0000_0000_7FFF_FFFF, RADIX_DEC, 1'b0, 1'b0, 1'b1);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b0, 1'b1, 1'b1);
        send_number(64'h0000_0000_8000_0000, RADIX_DEC, 1'b0, 1'b1, 1'b1);
        send_number(64'h0123_4567_89AB_CDEF, RADIX_SPARE, 1'b1, 1'b1, 1'b0);
        send_number(64'h0123_4567_89AB_CDEF, RADIX_SPARE, 1'b0, 1'b0, 1'b1);
        send_number(64'h8000_0000_0000_00AF, RADIX_HEX, 1'b0, 1'b1, 1'b1);
        send_number(64'h8000_0000_8000_0007, RADIX_OCT, 1'b1, 1'b0, 1'b1);
        send_number(64'd7, RADIX_OCT, 1'b1, 1'b0, 1'b0);
        send_number(64'd9, RADIX_DEC, 1'b1, 1'b1, 1'b1);
        send_number(64'd15, RADIX_HEX, 1'b1, 1'b0, 1'b0);
        send_number(64'd1, RADIX_DEC, 1'b0, 1'b0, 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            tx_idle_on = !(i >= 150 && i < 230);
            rx_idle_on = !(i >= 150 && i < 230);
            send_number(random_value(), 2'($urandom_range(0, 3)), 1'($urandom),
                        1'($urandom), 1'($urandom));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("converted %0d numbers in octal, decimal and hex at both widths,", numbers_sent);
        $display("%0d characters compared under random sender gaps and receiver stalls",
                 chars_checked);
        if (errors == 0 && chars_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
